// ===== rtl/dh_transform_pose_assert.svh =====
// Assertion macros for the pose transform RTL.
`ifndef DH_TRANSFORM_POSE_ASSERT_SVH
`define DH_TRANSFORM_POSE_ASSERT_SVH
// A condition that holds at every clock edge outside reset.
`define DTP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// An implication checked in the same cycle outside reset.
`define DTP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`endif

// ===== rtl/dtp_pkg.sv =====
// Types and constant tables for the pose transform pipeline.
package dtp_pkg;
   localparam int CW = 34;
   localparam int TURN_UNITS = 46080;
   localparam int HALF_UNITS = 23040;
   localparam int DIV45_MUL = 46604;
   localparam int DIV45_SHIFT = 21;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [CW-1:0] cordic_type;

   typedef struct packed {
      logic signed [23:0] link_length;
      logic signed [23:0] link_offset;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_z;
      logic               flip;
   } meta_type;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // Fractional phase of (m * 2^22 + 22) / 45 for a remainder m below 45.
   localparam logic [21:0] PH_FRAC [45] = '{
      22'((0*4194304+22)/45),  22'((1*4194304+22)/45),  22'((2*4194304+22)/45),
      22'((3*4194304+22)/45),  22'((4*4194304+22)/45),  22'((5*4194304+22)/45),
      22'((6*4194304+22)/45),  22'((7*4194304+22)/45),  22'((8*4194304+22)/45),
      22'((9*4194304+22)/45),  22'((10*4194304+22)/45), 22'((11*4194304+22)/45),
      22'((12*4194304+22)/45), 22'((13*4194304+22)/45), 22'((14*4194304+22)/45),
      22'((15*4194304+22)/45), 22'((16*4194304+22)/45), 22'((17*4194304+22)/45),
      22'((18*4194304+22)/45), 22'((19*4194304+22)/45), 22'((20*4194304+22)/45),
      22'((21*4194304+22)/45), 22'((22*4194304+22)/45), 22'((23*4194304+22)/45),
      22'((24*4194304+22)/45), 22'((25*4194304+22)/45), 22'((26*4194304+22)/45),
      22'((27*4194304+22)/45), 22'((28*4194304+22)/45), 22'((29*4194304+22)/45),
      22'((30*4194304+22)/45), 22'((31*4194304+22)/45), 22'((32*4194304+22)/45),
      22'((33*4194304+22)/45), 22'((34*4194304+22)/45), 22'((35*4194304+22)/45),
      22'((36*4194304+22)/45), 22'((37*4194304+22)/45), 22'((38*4194304+22)/45),
      22'((39*4194304+22)/45), 22'((40*4194304+22)/45), 22'((41*4194304+22)/45),
      22'((42*4194304+22)/45), 22'((43*4194304+22)/45), 22'((44*4194304+22)/45)
   };
endpackage

// ===== rtl/dtp_front.sv =====
// Angle reduction, phase conversion and quadrant folding ahead of the CORDIC chain.
module dtp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [23:0]        link_length,
   input  logic signed [16:0]        twist_angle,
   input  logic signed [23:0]        link_offset,
   input  logic signed [16:0]        joint_angle,
   output logic                      out_valid,
   input  logic                      out_ready,
   output dtp_pkg::cordic_type       out_z,
   output dtp_pkg::meta_type         out_meta
);
   import dtp_pkg::*;

   logic        v1_ff, v2_ff, v3_ff;
   logic        go1, go2, go3;
   logic [15:0] r1_ff, r2_ff;
   logic [15:0] ra, rt;
   logic [9:0]  q2_ff;
   logic [31:0] qprod;
   logic [5:0]  rem;
   logic [31:0] phase, fold;
   meta_type    m1_ff, m2_ff, m3_ff, m1_in, m3_in;
   cordic_type  z3_ff;

   function automatic logic [15:0] reduce(input logic signed [16:0] v);
      logic signed [17:0] t;
      t = 18'(v);
      if (t < 0) t = t + 18'(TURN_UNITS);
      if (t < 0) t = t + 18'(TURN_UNITS);
      if (t >= 18'(TURN_UNITS)) t = t - 18'(TURN_UNITS);
      return t[15:0];
   endfunction

   function automatic logic signed [15:0] wrap(input logic [15:0] r);
      return (r > 16'(HALF_UNITS)) ? 16'(r - 16'(TURN_UNITS)) : r;
   endfunction

   assign go3 = !v3_ff || out_ready;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;
   assign in_ready = go1;

   always_comb begin
      ra = reduce(twist_angle);
      rt = reduce(joint_angle);
      m1_in.link_length = link_length;
      m1_in.link_offset = link_offset;
      m1_in.rot_x = wrap(ra);
      m1_in.rot_z = wrap(rt);
      m1_in.flip = 1'b0;
      qprod = 32'(r1_ff) * 32'(DIV45_MUL);
      rem = 6'(r2_ff - 16'(q2_ff) * 16'd45);
      phase = {q2_ff, PH_FRAC[rem]};
      m3_in = m2_ff;
      m3_in.flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      fold = m3_in.flip ? {~phase[31], phase[30:0]} : phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (go1) v1_ff <= in_valid;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
      end
      if (go1) begin
         r1_ff <= rt;
         m1_ff <= m1_in;
      end
      if (go2) begin
         r2_ff <= r1_ff;
         q2_ff <= qprod[DIV45_SHIFT+9:DIV45_SHIFT];
         m2_ff <= m1_ff;
      end
      if (go3) begin
         z3_ff <= CW'($signed(fold));
         m3_ff <= m3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_z = z3_ff;
   assign out_meta = m3_ff;
endmodule

// ===== rtl/dtp_cordic_cell.sv =====
// One rotation-mode CORDIC cell with its own shift and arctangent constant.
module dtp_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dtp_pkg::cordic_type in_x,
   input  dtp_pkg::cordic_type in_y,
   input  dtp_pkg::cordic_type in_z,
   input  dtp_pkg::meta_type   in_meta,
   output logic                out_valid,
   input  logic                out_ready,
   output dtp_pkg::cordic_type out_x,
   output dtp_pkg::cordic_type out_y,
   output dtp_pkg::cordic_type out_z,
   output dtp_pkg::meta_type   out_meta
);
   import dtp_pkg::*;

   logic       valid_ff, go;
   cordic_type x_ff, y_ff, z_ff, x_in, y_in, z_in, dx, dy, da;
   meta_type   meta_ff;

   assign go = !valid_ff || out_ready;
   assign in_ready = go;

   always_comb begin
      dx = in_y >>> IDX;
      dy = in_x >>> IDX;
      da = CW'(ATAN_TAB[IDX]);
      if (in_z >= 0) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - da;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (go) begin
         valid_ff <= in_valid;
      end
      if (go) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
   assign out_meta = meta_ff;
endmodule

// ===== rtl/dtp_back.sv =====
// Sign restore, scaling of the link length, rounding and saturation to the result item.
module dtp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dtp_pkg::cordic_type in_x,
   input  dtp_pkg::cordic_type in_y,
   input  dtp_pkg::meta_type   in_meta,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [23:0]  trans_x,
   output logic signed [23:0]  trans_y,
   output logic signed [23:0]  trans_z,
   output logic signed [15:0]  rot_x,
   output logic signed [15:0]  rot_z
);
   import dtp_pkg::*;

   logic               va_ff, vb_ff, goa, gob;
   cordic_type         cx, cy;
   logic signed [57:0] px_ff, py_ff, px_in, py_in;
   meta_type           ma_ff;
   logic signed [23:0] tx_ff, ty_ff, tz_ff;
   logic signed [15:0] rx_ff, rz_ff;

   function automatic logic signed [23:0] round_sat(input logic signed [57:0] p);
      logic signed [57:0] s;
      s = (p + 58'sd536870912) >>> 30;
      if (s > 58'sd8388607) return 24'sd8388607;
      if (s < -58'sd8388608) return -24'sd8388608;
      return s[23:0];
   endfunction

   assign gob = !vb_ff || out_ready;
   assign goa = !va_ff || gob;
   assign in_ready = goa;

   always_comb begin
      cx = in_meta.flip ? -in_x : in_x;
      cy = in_meta.flip ? -in_y : in_y;
      px_in = 58'(in_meta.link_length) * 58'(cx);
      py_in = 58'(in_meta.link_length) * 58'(cy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (goa) va_ff <= in_valid;
         if (gob) vb_ff <= va_ff;
      end
      if (goa) begin
         px_ff <= px_in;
         py_ff <= py_in;
         ma_ff <= in_meta;
      end
      if (gob) begin
         tx_ff <= round_sat(px_ff);
         ty_ff <= round_sat(py_ff);
         tz_ff <= ma_ff.link_offset;
         rx_ff <= ma_ff.rot_x;
         rz_ff <= ma_ff.rot_z;
      end
   end

   assign out_valid = vb_ff;
   assign trans_x = tx_ff;
   assign trans_y = ty_ff;
   assign trans_z = tz_ff;
   assign rot_x = rx_ff;
   assign rot_z = rz_ff;
endmodule

// ===== rtl/dh_transform_pose.sv =====
// An accepted item passes the front stages, CORDIC_STAGES cells and the back stages (cells cap at 32).
// Throughput is one item per cycle while rsp_ready is high; each stage and cell holds one item.
// Three front stages reduce the angles, the cell chain rotates, two back stages scale.
// A stalled output stalls only the stages that hold an item; bubbles upstream still fill.
// Synchronous reset clears the valid bits of all stages; payload registers are not reset.
module dh_transform_pose #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_link_length,
   input  logic signed [16:0] req_twist_angle,
   input  logic signed [23:0] req_link_offset,
   input  logic signed [16:0] req_joint_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_trans_x,
   output logic signed [23:0] rsp_trans_y,
   output logic signed [23:0] rsp_trans_z,
   output logic signed [15:0] rsp_rot_x,
   output logic signed [15:0] rsp_rot_y,
   output logic signed [15:0] rsp_rot_z
);
   import dtp_pkg::*;
`include "dh_transform_pose_assert.svh"

   localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   logic       cv [N+1];
   logic       cr [N+1];
   cordic_type cx [N+1];
   cordic_type cy [N+1];
   cordic_type cz [N+1];
   meta_type   cm [N+1];
   logic       rot_x_ok, rot_z_ok;

   dtp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .link_length(req_link_length), .twist_angle(req_twist_angle),
      .link_offset(req_link_offset), .joint_angle(req_joint_angle),
      .out_valid(cv[0]), .out_ready(cr[0]), .out_z(cz[0]), .out_meta(cm[0])
   );

   assign cx[0] = CORDIC_GAIN;
   assign cy[0] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      dtp_cordic_cell #(.IDX(i)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(cv[i]), .in_ready(cr[i]),
         .in_x(cx[i]), .in_y(cy[i]), .in_z(cz[i]), .in_meta(cm[i]),
         .out_valid(cv[i+1]), .out_ready(cr[i+1]),
         .out_x(cx[i+1]), .out_y(cy[i+1]), .out_z(cz[i+1]), .out_meta(cm[i+1])
      );
   end

   dtp_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(cv[N]), .in_ready(cr[N]),
      .in_x(cx[N]), .in_y(cy[N]), .in_meta(cm[N]),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .trans_x(rsp_trans_x), .trans_y(rsp_trans_y), .trans_z(rsp_trans_z),
      .rot_x(rsp_rot_x), .rot_z(rsp_rot_z)
   );

   assign rsp_rot_y = '0;

   assign rot_x_ok = (rsp_rot_x <= HALF_UNITS) && (rsp_rot_x > -HALF_UNITS);
   assign rot_z_ok = (rsp_rot_z <= HALF_UNITS) && (rsp_rot_z > -HALF_UNITS);

   `DTP_ASSERT_ALWAYS(a_ready_when_empty, req_ready || rsp_valid, "stall with empty output")
   `DTP_ASSERT_IMPLY(a_rot_x_range, rsp_valid, rot_x_ok, "rot_x out of range")
   `DTP_ASSERT_IMPLY(a_rot_z_range, rsp_valid, rot_z_ok, "rot_z out of range")
   `DTP_ASSERT_IMPLY(a_rot_y_zero, rsp_valid, rsp_rot_y == 16'sd0, "rot_y not zero")
endmodule
